/* design/nfkv_pkg.sv */
// Shared constants and types for the newest-first key/value table.
package nfkv_pkg;

    localparam int DEPTH  = 16;
    localparam int KEY_W  = 32;
    localparam int PRIO_W = 31;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    localparam logic [KEY_W-1:0] NONE_PRIO = '1;

    // Search token walking down the cell chain, newest entry first.
    typedef struct packed {
        logic              active;
        logic              found;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;      // new priority in, found priority out
        logic [CNT_W-1:0]  remaining; // live entries from this cell onward
    } tok_t;

endpackage

/* design/nfkv_if.sv */
// Request and response channel interfaces.
interface nfkv_req_if;
    logic                                valid;
    logic                                ready;
    logic [nfkv_pkg::OP_W-1:0]           op;
    logic signed [nfkv_pkg::KEY_W-1:0]   key;
    logic [nfkv_pkg::PRIO_W-1:0]         new_priority;

    modport source (output valid, output op, output key, output new_priority, input ready);
    modport sink (input valid, input op, input key, input new_priority, output ready);
endinterface

interface nfkv_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [nfkv_pkg::STAT_W-1:0]         status;
    logic signed [nfkv_pkg::KEY_W-1:0]   echo_key;
    logic signed [nfkv_pkg::KEY_W-1:0]   found_priority;

    modport source (output valid, output status, output echo_key, output found_priority,
                    input ready);
    modport sink (input valid, input status, input echo_key, input found_priority,
                  output ready);
endinterface

/* design/nfkv_cell.sv */
// One table entry: shifts on insert, checks and forwards the search token.
module nfkv_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_en,
    input  logic [nfkv_pkg::KEY_W-1:0]    shift_key,
    input  logic [nfkv_pkg::PRIO_W-1:0]   shift_prio,
    input  nfkv_pkg::tok_t                tok_in,
    output logic [nfkv_pkg::KEY_W-1:0]    key,
    output logic [nfkv_pkg::PRIO_W-1:0]   prio,
    output nfkv_pkg::tok_t                tok_out
);

    logic [nfkv_pkg::KEY_W-1:0]  key_reg;
    logic [nfkv_pkg::PRIO_W-1:0] prio_reg;
    nfkv_pkg::tok_t              tok_reg;
    nfkv_pkg::tok_t              tok_next;
    logic                        hit;

    // first live match seen by the token is the newest one
    assign hit = tok_in.active && (tok_in.remaining != '0) && !tok_in.found
                 && (key_reg == tok_in.key);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.remaining != '0)
        begin
            tok_next.remaining = tok_in.remaining - 1'b1;
        end
        if (hit)
        begin
            tok_next.found = 1'b1;
            if (tok_in.op == nfkv_pkg::OP_LOOKUP)
            begin
                tok_next.prio = prio_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg  <= shift_key;
            prio_reg <= shift_prio;
        end
        else if (hit && (tok_in.op == nfkv_pkg::OP_UPDATE))
        begin
            prio_reg <= tok_in.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign key     = key_reg;
    assign prio    = prio_reg;
    assign tok_out = tok_reg;

endmodule

/* design/newest_first_key_value_table.sv */
// Top level of the newest-first key/value table: cell chain plus control.
//
//  channel | modport | payload                              | accepted when
//  req     | sink    | op, key, new_priority                | valid & ready
//  rsp     | source  | status, echo_key, found_priority     | valid & ready
//
// Insert and unused ops answer in the cycle after acceptance; the entries sit in a
// shift chain with the newest at cell 0.
// Lookup and update send a token down the chain, one cell per cycle: the answer
// is registered when the token leaves the last cell, one request in flight.
// Reset empties the table at once (entry count to zero); no clearing pass.
// A stalled response holds; a new request is taken once the output is free.
module newest_first_key_value_table
(
    input  logic        clk,
    input  logic        rst_n,
    nfkv_req_if.sink    req,
    nfkv_rsp_if.source  rsp
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    logic [nfkv_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic                            load;
    logic [nfkv_pkg::STAT_W-1:0]     status_reg, status_next;
    logic [nfkv_pkg::KEY_W-1:0]      echo_reg, echo_next;
    logic [nfkv_pkg::KEY_W-1:0]      fprio_reg, fprio_next;

    logic                            accept;
    logic                            full;
    logic                            shift_en;
    nfkv_pkg::tok_t                  tok_head;
    nfkv_pkg::tok_t                  tok [nfkv_pkg::DEPTH];
    logic [nfkv_pkg::KEY_W-1:0]      cell_key [nfkv_pkg::DEPTH];
    logic [nfkv_pkg::PRIO_W-1:0]     cell_prio [nfkv_pkg::DEPTH];
    nfkv_pkg::tok_t                  tail;

    assign full      = (cnt_reg == nfkv_pkg::CNT_W'(nfkv_pkg::DEPTH));
    assign req.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign shift_en  = accept && (req.op == nfkv_pkg::OP_INSERT) && !full;

    always_comb
    begin
        tok_head.active    = accept && (req.op inside {nfkv_pkg::OP_LOOKUP,
                                                       nfkv_pkg::OP_UPDATE});
        tok_head.found     = 1'b0;
        tok_head.op        = req.op;
        tok_head.key       = req.key;
        tok_head.prio      = req.new_priority;
        tok_head.remaining = cnt_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < nfkv_pkg::DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                nfkv_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift_en   (shift_en),
                    .shift_key  (req.key),
                    .shift_prio (req.new_priority),
                    .tok_in     (tok_head),
                    .key        (cell_key[gi]),
                    .prio       (cell_prio[gi]),
                    .tok_out    (tok[gi])
                );
            end
            else
            begin : g_body
                nfkv_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift_en   (shift_en),
                    .shift_key  (cell_key[gi-1]),
                    .shift_prio (cell_prio[gi-1]),
                    .tok_in     (tok[gi-1]),
                    .key        (cell_key[gi]),
                    .prio       (cell_prio[gi]),
                    .tok_out    (tok[gi])
                );
            end
        end
    endgenerate

    assign tail = tok[nfkv_pkg::DEPTH-1];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        load           = 1'b0;
        status_next    = nfkv_pkg::STAT_MISS;
        echo_next      = req.key;
        fprio_next     = nfkv_pkg::NONE_PRIO;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.op)
                        nfkv_pkg::OP_INSERT:
                        begin
                            load = 1'b1;
                            if (full)
                            begin
                                status_next = nfkv_pkg::STAT_FULL;
                            end
                            else
                            begin
                                status_next = nfkv_pkg::STAT_DONE;
                                cnt_next    = cnt_reg + 1'b1;
                            end
                        end
                        nfkv_pkg::OP_LOOKUP, nfkv_pkg::OP_UPDATE:
                        begin
                            state_next = ST_WALK;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (tail.active)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                    echo_next  = tail.key;
                    if (tail.found)
                    begin
                        status_next = nfkv_pkg::STAT_DONE;
                        if (tail.op == nfkv_pkg::OP_LOOKUP)
                        begin
                            fprio_next = {1'b0, tail.prio};
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            echo_reg   <= echo_next;
            fprio_reg  <= fprio_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.echo_key       = echo_reg;
    assign rsp.found_priority = fprio_reg;

endmodule

/* design/nfkv_checker.sv */
// Port-level checks for the key/value table, bound to the top level.
module nfkv_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic [nfkv_pkg::OP_W-1:0]     req_op,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [nfkv_pkg::STAT_W-1:0]   rsp_status,
    input  logic [nfkv_pkg::KEY_W-1:0]    rsp_echo_key,
    input  logic [nfkv_pkg::KEY_W-1:0]    rsp_found_priority
);

    // stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_echo_key) && $stable(rsp_found_priority))
        else $error("response changed while stalled");

    // a search request blocks new requests and gives no response next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready
            && (req_op == nfkv_pkg::OP_LOOKUP || req_op == nfkv_pkg::OP_UPDATE)
        |=> !req_ready && !rsp_valid)
        else $error("search request did not occupy the chain");

    // insert answers on the next cycle with done or full
    a_insert_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_op == nfkv_pkg::OP_INSERT
        |=> rsp_valid && (rsp_status == nfkv_pkg::STAT_DONE
            || rsp_status == nfkv_pkg::STAT_FULL)
            && rsp_found_priority == nfkv_pkg::NONE_PRIO)
        else $error("insert response wrong");

    // any response that is not a done carries the no-priority marker
    a_miss_prio: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != nfkv_pkg::STAT_DONE
        |-> rsp_found_priority == nfkv_pkg::NONE_PRIO)
        else $error("priority reported without a hit");

endmodule

bind newest_first_key_value_table nfkv_checker u_nfkv_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_op             (req.op),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_echo_key       (rsp.echo_key),
    .rsp_found_priority (rsp.found_priority)
);
